>>> rtl/core/npl_pkg.sv
// Package for the nearest palette Lab match block: field widths, opcodes,
// palette entry layout and sequencer states. No dependencies.
package npl_pkg;

    // Default palette depth
    localparam int unsigned PALETTE_DEPTH_DEF = 256;

    // Field widths
    localparam int unsigned L_W     = 14;
    localparam int unsigned AB_W    = 15;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned DIST_W  = 32;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    // One stored palette color
    typedef struct packed {
        logic [L_W-1:0]         l;
        logic signed [AB_W-1:0] a;
        logic signed [AB_W-1:0] b;
    } t_entry;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

>>> rtl/core/nearest_palette_lab_match_top.sv
// Top level of the nearest palette Lab match block: palette memory, scan
// sequencer and one shared squared-distance and compare unit.
// Depends on npl_pkg.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------------------
//  input    | in        | i_valid / o_ready         | operation, entry_index, l, a, b value
//  result   | out       | o_valid / i_ready         | best_index, best_distance_sq, found
//  config   | in        | i_cfg_valid / o_cfg_ready | palette_count (9 bits)
//
// A load transaction writes the palette memory directly. A match transaction
// scans N = min(palette_count, depth) entries: the one read port of the palette
// memory supplies one entry per cycle to the distance unit, whose pipeline
// registers the read, the squares and the running best; an empty palette skips it.
// Reset clears the sequencer, the count and the result register; the palette
// memory holds no reset value. A stalled result holds the block in its final
// state until the result register frees; load and config take effect at once.
module nearest_palette_lab_match_top #(
    parameter int unsigned PALETTE_DEPTH = npl_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_operation,
    input  logic [npl_pkg::IDX_W-1:0]         i_entry_index,
    input  logic [npl_pkg::L_W-1:0]           i_l_value,
    input  logic signed [npl_pkg::AB_W-1:0]   i_a_value,
    input  logic signed [npl_pkg::AB_W-1:0]   i_b_value,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [npl_pkg::IDX_W-1:0]         o_best_index,
    output logic [npl_pkg::DIST_W-1:0]        o_best_distance_sq,
    output logic                              o_found,
    // config channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [npl_pkg::COUNT_W-1:0]       i_cfg_data
);

    localparam int unsigned AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned CAP = (PALETTE_DEPTH > 511) ? 511 : PALETTE_DEPTH;
    localparam int unsigned CW  = npl_pkg::COUNT_W;

    npl_pkg::t_state r_state, n_state;

    // Configuration and pixel latch
    logic [CW-1:0]                     r_palette_count;
    logic [CW-1:0]                     r_limit;
    logic [npl_pkg::L_W-1:0]           r_pix_l;
    logic signed [npl_pkg::AB_W-1:0]   r_pix_a;
    logic signed [npl_pkg::AB_W-1:0]   r_pix_b;

    // Scan counter and pipeline
    logic [CW-1:0]         r_idx;
    logic                  r_v1, r_v2;
    logic                  r_last1, r_last2;
    logic [CW-1:0]         r_i1, r_i2;
    npl_pkg::t_entry       r_rd_data;
    logic [27:0]           r_sq_l;
    logic [29:0]           r_sq_a, r_sq_b;

    // Running best
    logic                          r_have;
    logic [CW-1:0]                 r_best_i;
    logic [npl_pkg::DIST_W-1:0]    r_best_d;

    // Result register
    logic                          r_out_valid;
    logic [npl_pkg::IDX_W-1:0]     r_out_idx;
    logic [npl_pkg::DIST_W-1:0]    r_out_dist;
    logic                          r_out_found;

    // Palette memory
    npl_pkg::t_entry mem [PALETTE_DEPTH];

    logic                  w_accept;
    logic                  w_load;
    logic                  w_rd_en;
    logic                  w_issue_last;
    logic                  w_out_load;
    logic [CW-1:0]         w_limit;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    npl_pkg::t_entry       w_wr_data;

    logic signed [npl_pkg::L_W:0]    w_dl;
    logic signed [npl_pkg::AB_W:0]   w_da, w_db;
    logic [npl_pkg::L_W-1:0]         w_mag_l;
    logic [npl_pkg::AB_W-1:0]        w_mag_a, w_mag_b;
    logic [npl_pkg::DIST_W-1:0]      w_dist;
    logic                            w_better;

    assign w_accept     = i_valid && o_ready;
    assign w_load       = w_accept && (i_operation == npl_pkg::OP_LOAD)
                          && (32'(i_entry_index) < PALETTE_DEPTH);
    assign w_issue_last = (r_idx == (r_limit - CW'(1)));
    assign w_rd_addr    = AW'(r_idx);
    assign w_wr_addr    = AW'(i_entry_index);
    assign w_wr_data    = '{l: i_l_value, a: i_a_value, b: i_b_value};
    assign w_limit      = (r_palette_count > CW'(CAP)) ? CW'(CAP) : r_palette_count;

    assign o_cfg_ready  = 1'b1;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer outputs
    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        w_rd_en    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            npl_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && (i_operation == npl_pkg::OP_MATCH)) begin
                    n_state = (w_limit == '0) ? npl_pkg::ST_FINISH : npl_pkg::ST_SCAN;
                end
            end
            npl_pkg::ST_SCAN: begin
                w_rd_en = 1'b1;
                if (w_issue_last) begin
                    n_state = npl_pkg::ST_DRAIN;
                end
            end
            npl_pkg::ST_DRAIN: begin
                if (r_v2 && r_last2) begin
                    n_state = npl_pkg::ST_FINISH;
                end
            end
            npl_pkg::ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = npl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npl_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the palette count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_palette_count <= i_cfg_data;
        end
    end

    // Latch the pixel and scan limit on a match transaction
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_operation == npl_pkg::OP_MATCH)) begin
            r_pix_l <= i_l_value;
            r_pix_a <= i_a_value;
            r_pix_b <= i_b_value;
            r_limit <= w_limit;
        end
    end

    // Palette write and registered read
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // Advance the scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_accept) begin
            r_idx <= '0;
        end else if (w_rd_en) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // Pipeline valid and last flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_last1 <= 1'b0;
            r_last2 <= 1'b0;
        end else begin
            r_v1    <= w_rd_en;
            r_v2    <= r_v1;
            r_last1 <= w_rd_en && w_issue_last;
            r_last2 <= r_last1;
        end
    end

    // Absolute differences of the pixel against the entry just read
    always_comb begin
        w_dl    = $signed({1'b0, r_pix_l}) - $signed({1'b0, r_rd_data.l});
        w_da    = $signed({r_pix_a[npl_pkg::AB_W-1], r_pix_a})
                  - $signed({r_rd_data.a[npl_pkg::AB_W-1], r_rd_data.a});
        w_db    = $signed({r_pix_b[npl_pkg::AB_W-1], r_pix_b})
                  - $signed({r_rd_data.b[npl_pkg::AB_W-1], r_rd_data.b});
        w_mag_l = w_dl[npl_pkg::L_W]  ? npl_pkg::L_W'(-w_dl)  : npl_pkg::L_W'(w_dl);
        w_mag_a = w_da[npl_pkg::AB_W] ? npl_pkg::AB_W'(-w_da) : npl_pkg::AB_W'(w_da);
        w_mag_b = w_db[npl_pkg::AB_W] ? npl_pkg::AB_W'(-w_db) : npl_pkg::AB_W'(w_db);
    end

    // Square the differences
    always_ff @(posedge i_clk) begin
        r_i1   <= r_idx;
        r_i2   <= r_i1;
        r_sq_l <= 28'(w_mag_l) * 28'(w_mag_l);
        r_sq_a <= 30'(w_mag_a) * 30'(w_mag_a);
        r_sq_b <= 30'(w_mag_b) * 30'(w_mag_b);
    end

    // Sum and compare against the running best; strict less keeps the lowest index
    assign w_dist   = npl_pkg::DIST_W'(r_sq_l) + npl_pkg::DIST_W'(r_sq_a)
                      + npl_pkg::DIST_W'(r_sq_b);
    assign w_better = !r_have || (w_dist < r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_best_i <= '0;
            r_best_d <= '0;
        end else if (w_accept && (i_operation == npl_pkg::OP_MATCH)) begin
            r_have   <= 1'b0;
            r_best_i <= '0;
            r_best_d <= '0;
        end else if (r_v2 && w_better) begin
            r_have   <= 1'b1;
            r_best_i <= r_i2;
            r_best_d <= w_dist;
        end
    end

    // Result register: free on acceptance, load from the finished scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_idx   <= '0;
            r_out_dist  <= '0;
            r_out_found <= 1'b0;
        end else if (w_out_load) begin
            r_out_idx   <= npl_pkg::IDX_W'(r_best_i);
            r_out_dist  <= r_best_d;
            r_out_found <= r_have;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_best_index       = r_out_idx;
    assign o_best_distance_sq = r_out_dist;
    assign o_found            = r_out_found;

`ifndef ASSERT_OFF
    // Read issue stays inside the searched range
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npl_pkg::ST_SCAN) |-> (r_idx < r_limit))
        else $error("scan index beyond palette limit");

    // Pipeline data only exists while a scan is in flight
    a_pipe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> (r_state == npl_pkg::ST_SCAN || r_state == npl_pkg::ST_DRAIN))
        else $error("distance pipeline active outside a scan");

    // Stage two is valid only in the cycle after stage one
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("stage two valid without stage one");

    // An empty search reports index and distance zero
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_idx == '0 && r_out_dist == '0))
        else $error("not-found result carries nonzero fields");

    // A loaded result is presented on the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> r_out_valid)
        else $error("result register lost a finished match");
`endif

endmodule

>>> tb/npl_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the nearest palette Lab match testbench: a palette shadow, the
// match predictor and the queue of predicted match results. Depends on npl_pkg.
package npl_tb_pkg;

    import npl_pkg::*;

    // One predicted match result
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
        logic              found;
    } t_match_result;

    class match_scoreboard;

        t_entry          palette [PALETTE_DEPTH_DEF];
        bit              written [PALETTE_DEPTH_DEF];
        int unsigned     search_count;
        t_match_result   result_q[$];
        int unsigned     error_count;

        function new();
            search_count = 0;
            error_count  = 0;
            foreach (written[i]) begin
                written[i] = 1'b0;
                palette[i] = '0;
            end
        endfunction

        // Track the count register; values past the depth search everything
        function void write_count(logic [COUNT_W-1:0] value);
            search_count = (value > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : value;
        endfunction

        // Squared CIE76 distance between two colors in fixed-point units of 1/128
        function longint unsigned dist_sq(t_entry p, t_entry q);
            longint dl;
            longint da;
            longint db;
            dl = longint'(p.l) - longint'(q.l);
            da = longint'($signed(p.a)) - longint'($signed(q.a));
            db = longint'($signed(p.b)) - longint'($signed(q.b));
            return dl * dl + da * da + db * db;
        endfunction

        // Apply one accepted input transaction; a match queues its result
        function void note_input(logic op, logic [IDX_W-1:0] slot, t_entry color);
            t_match_result     res;
            longint unsigned   d;
            if (op == OP_LOAD) begin
                if (slot < PALETTE_DEPTH_DEF) begin
                    palette[slot] = color;
                    written[slot] = 1'b1;
                end
                return;
            end
            res = '0;
            for (int unsigned i = 0; i < search_count; i++) begin
                d = dist_sq(color, palette[i]);
                // strict compare keeps the lowest index on ties
                if (!res.found || d < res.distance) begin
                    res.found    = 1'b1;
                    res.distance = d[DIST_W-1:0];
                    res.index    = i[IDX_W-1:0];
                end
            end
            result_q.push_back(res);
        endfunction

        // Compare one accepted result transaction with the oldest prediction
        function void check_result(logic [IDX_W-1:0] index, logic [DIST_W-1:0] distance,
                                   logic found);
            t_match_result want;
            if (result_q.size() == 0) begin
                $error("result transaction with no match pending: index %0d distance %0d found %0d",
                       index, distance, found);
                error_count++;
                return;
            end
            want = result_q.pop_front();
            if (found !== want.found) begin
                $error("found mismatch: expected %0d, actual %0d", want.found, found);
                error_count++;
            end
            if (index !== want.index) begin
                $error("best_index mismatch: expected %0d, actual %0d", want.index, index);
                error_count++;
            end
            if (distance !== want.distance) begin
                $error("best_distance_sq mismatch: expected %0d, actual %0d",
                       want.distance, distance);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

    endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the nearest palette Lab match testbench: clock, reset, drivers for the
// input, result and count channels, directed and random stimulus.
// Depends on npl_pkg, npl_tb_pkg and nearest_palette_lab_match_top.
module tb_top;

    import npl_pkg::*;
    import npl_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic                    i_operation   = OP_LOAD;
    logic [IDX_W-1:0]        i_entry_index = '0;
    logic [L_W-1:0]          i_l_value     = '0;
    logic signed [AB_W-1:0]  i_a_value     = '0;
    logic signed [AB_W-1:0]  i_b_value     = '0;
    logic                    i_ready       = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    logic [COUNT_W-1:0]      i_cfg_data    = '0;
    logic                    o_ready;
    logic                    o_valid;
    logic [IDX_W-1:0]        o_best_index;
    logic [DIST_W-1:0]       o_best_distance_sq;
    logic                    o_found;
    logic                    o_cfg_ready;

    int unsigned             send_idle_pct = 18;
    int unsigned             recv_idle_pct = 59;
    int unsigned             random_sent   = 0;
    match_scoreboard         board;

    nearest_palette_lab_match_top #(
        .PALETTE_DEPTH(PALETTE_DEPTH_DEF)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_entry_index      (i_entry_index),
        .i_l_value          (i_l_value),
        .i_a_value          (i_a_value),
        .i_b_value          (i_b_value),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_best_index       (o_best_index),
        .o_best_distance_sq (o_best_distance_sq),
        .o_found            (o_found),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result(o_best_index, o_best_distance_sq, o_found);
        end
    end

    // Send one input transaction, idling first at random
    task automatic send_item(input logic op, input logic [IDX_W-1:0] slot, input t_entry color);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_entry_index <= slot;
        i_l_value     <= color.l;
        i_a_value     <= color.a;
        i_b_value     <= color.b;
        do @(posedge i_clk); while (!o_ready);
        board.note_input(op, slot, color);
    endtask

    // Drain the block, then write the palette count register
    task automatic write_count_reg(input logic [COUNT_W-1:0] value);
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_count(value);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_entry make_color(input int unsigned l, input int a, input int b);
        t_entry c;
        c.l = L_W'(l);
        c.a = AB_W'(a);
        c.b = AB_W'(b);
        return c;
    endfunction

    // Coarse grid colors make ties common; full range reaches every bit
    function automatic t_entry random_color(input bit grid);
        t_entry c;
        if (grid) begin
            c.l = L_W'($urandom_range(0, 4) * 3200);
            c.a = AB_W'(int'($urandom_range(0, 4)) * 4096 - 8192);
            c.b = AB_W'(int'($urandom_range(0, 4)) * 4096 - 8192);
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                c.l = L_W'($urandom_range(12801, 16383));
            end else begin
                c.l = L_W'($urandom_range(0, 12800));
            end
            c.a = AB_W'($urandom_range(0, 32767));
            c.b = AB_W'($urandom_range(0, 32767));
        end
        return c;
    endfunction

    // Mostly small palettes, a few full ones and counts past the depth
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)       return '0;
        else if (r < 15) return COUNT_W'(1);
        else if (r < 65) return COUNT_W'($urandom_range(2, 16));
        else if (r < 85) return COUNT_W'($urandom_range(17, 64));
        else if (r < 93) return COUNT_W'($urandom_range(65, 255));
        else if (r < 97) return COUNT_W'(PALETTE_DEPTH_DEF);
        else             return COUNT_W'($urandom_range(PALETTE_DEPTH_DEF + 1, 511));
    endfunction

    // Swap the idle rates across the random part, then run without idling
    task automatic set_idle_mode();
        case (random_sent * 3 / RANDOM_ITEMS)
            0: begin
                send_idle_pct = 18;
                recv_idle_pct = 59;
            end
            1: begin
                send_idle_pct = 59;
                recv_idle_pct = 18;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    initial begin
        board = new();
        #100_000_000;
        $display("FAIL nearest_palette_lab_match_top");
        $finish;
    end

    initial begin
        logic [COUNT_W-1:0] count;
        int unsigned        limit;
        int unsigned        phase_len;
        bit                 grid;
        t_entry             color;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty palette after reset gives not found
        send_item(OP_MATCH, 8'd0, make_color(0, 0, 0));
        send_item(OP_MATCH, 8'd255, make_color(16383, -16384, 16383));

        // Extreme colors, a duplicate entry and a midpoint entry
        send_item(OP_LOAD, 8'd0, make_color(0, -16384, -16384));
        send_item(OP_LOAD, 8'd1, make_color(12800, 16383, 16383));
        send_item(OP_LOAD, 8'd2, make_color(0, -16384, -16384));
        send_item(OP_LOAD, 8'd3, make_color(6400, 0, 0));
        // Load a slot past the count
        send_item(OP_LOAD, 8'd255, make_color(16383, -1, 1));
        write_count_reg(COUNT_W'(4));

        // Exact hit tied with the duplicate, ignored index field, largest field values
        send_item(OP_MATCH, 8'd0, make_color(0, -16384, -16384));
        send_item(OP_MATCH, 8'd255, make_color(12800, 16383, 16383));
        send_item(OP_MATCH, 8'd170, make_color(16383, 16383, 16383));
        send_item(OP_MATCH, 8'd85, make_color(6400, 1, -1));
        // Equal distance to slots 0, 2 and 3
        send_item(OP_MATCH, 8'd3, make_color(3200, -8192, -8192));

        write_count_reg(COUNT_W'(1));
        send_item(OP_MATCH, 8'd0, make_color(16383, 16383, 16383));
        write_count_reg('0);
        send_item(OP_MATCH, 8'd1, make_color(12800, 0, 0));

        // Random phases: fill the searched slots, set the count, then mix
        while (random_sent < RANDOM_ITEMS) begin
            count = pick_count();
            grid  = ($urandom_range(0, 2) == 0);
            limit = (count > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : count;
            for (int unsigned s = 0; s < limit; s++) begin
                if (!board.written[s]) begin
                    set_idle_mode();
                    send_item(OP_LOAD, IDX_W'(s), random_color(grid));
                    random_sent++;
                end
            end
            write_count_reg(count);
            phase_len = $urandom_range(16, 48);
            repeat (phase_len) begin
                set_idle_mode();
                color = random_color(grid);
                if ($urandom_range(0, 99) < 65) begin
                    send_item(OP_MATCH, IDX_W'($urandom_range(0, 255)), color);
                end else begin
                    send_item(OP_LOAD, IDX_W'($urandom_range(0, 255)), color);
                end
                random_sent++;
            end
        end

        // Drain and let any late result show up
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (board.error_count == 0 && board.pending() == 0) begin
            $display("PASS nearest_palette_lab_match_top");
        end else begin
            $display("FAIL nearest_palette_lab_match_top");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/npl_pkg.sv
rtl/core/nearest_palette_lab_match_top.sv
tb/npl_tb_pkg.sv
tb/tb_top.sv
